// ===== design/tpq_pkg.sv =====
`timescale 1ns / 1ps
package tpq_pkg;

  localparam int TimeW  = 48;
  localparam int DelayW = 32;
  localparam int CountW = 16;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [TimeW-1:0]  expiry;
    logic [DelayW-1:0] delay;
    logic [CountW-1:0] count;
  } slot_t;

endpackage

// ===== design/tpq_in_if.sv =====
`timescale 1ns / 1ps
interface tpq_in_if import tpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [DelayW-1:0] delay_ticks;
  logic [CountW-1:0] fire_count;
  logic [3:0]        cancel_id;

  modport source (output valid, req_type, delay_ticks, fire_count, cancel_id, input ready);
  modport sink (input valid, req_type, delay_ticks, fire_count, cancel_id, output ready);
endinterface

// ===== design/tpq_out_if.sv =====
`timescale 1ns / 1ps
interface tpq_out_if import tpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [3:0]        slot_id;
  logic              fired;
  logic [CountW-1:0] count_left;
  logic [TimeW-1:0]  next_expiry;
  logic              queue_empty;
  logic              last;

  modport source (output valid, status, slot_id, fired, count_left, next_expiry,
                  queue_empty, last, input ready);
  modport sink (input valid, status, slot_id, fired, count_left, next_expiry,
                queue_empty, last, output ready);
endinterface

// ===== design/timer_priority_queue_top.sv =====
`timescale 1ns / 1ps
// The time of a request depends on N = NUM_TIMERS for every request, on s (lowest free
// slot, N when full) for an add and on F (timers due) for a tick.
// Once a result is taken, the next passes through S_LD_RD and S_LD before it is valid; one request
// at a time. The time is set by the slot memory scans, one slot read per cycle.
// Reset (rst_n, synchronous, active low) empties the table and zeroes the tick counter.
module timer_priority_queue_top import tpq_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tpq_in_if.sink    in_chan,
  tpq_out_if.source out_chan
);

  localparam int N  = NUM_TIMERS;
  localparam int IW = $clog2(N);
  localparam int SW = $clog2(N + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FREE  = 9'b000000010,
    S_DUE   = 9'b000000100,
    S_PICK  = 9'b000001000,
    S_PROC  = 9'b000010000,
    S_MIN   = 9'b000100000,
    S_LD_RD = 9'b001000000,
    S_LD    = 9'b010000000,
    S_WAIT  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic [IW-1:0]     id;
    logic [CountW-1:0] left;
  } fire_t;

  state_t state_r, state_nxt;
  logic [SW-1:0] scan_r, scan_nxt;
  logic rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [N-1:0] valid_r, valid_nxt, due_r, due_nxt;
  logic [TimeW-1:0] now_r, now_nxt;
  logic [1:0] req_r, req_nxt;
  logic [DelayW-1:0] delay_r, delay_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [1:0] hdr_sts_r, hdr_sts_nxt;
  logic [3:0] hdr_id_r, hdr_id_nxt;
  logic [SW-1:0] nf_r, nf_nxt, oi_r, oi_nxt;
  logic found_r, found_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  logic [TimeW-1:0] best_r, best_nxt;
  logic [CountW-1:0] pcnt_r, pcnt_nxt;
  logic [DelayW-1:0] pdly_r, pdly_nxt;
  logic any_r, any_nxt;
  logic [TimeW-1:0] min_r, min_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_sts_r, out_sts_nxt;
  logic [3:0] out_id_r, out_id_nxt;
  logic out_fired_r, out_fired_nxt;
  logic [CountW-1:0] out_left_r, out_left_nxt;
  logic [TimeW-1:0] out_next_r, out_next_nxt;
  logic out_empty_r, out_empty_nxt;
  logic out_last_r, out_last_nxt;

  slot_t mem [N];
  slot_t mem_q;
  logic mem_we;
  logic [IW-1:0] mem_wa;
  slot_t mem_wd;
  logic [IW-1:0] rd_addr;

  fire_t rbuf [N];
  fire_t rbuf_q;
  logic rb_we;
  logic [IW-1:0] rb_wa;
  fire_t rb_wd;

  logic scan_done;
  logic [IW-1:0] cid_idx, scan_idx;
  logic [CountW-1:0] new_cnt;

  assign rd_addr = (scan_r < SW'(N)) ? scan_r[IW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rb_we) begin
      rbuf[rb_wa] <= rb_wd;
    end
    rbuf_q <= rbuf[oi_r[IW-1:0]];
  end

  assign scan_done = rd_vld_r && (rd_idx_r == IW'(N - 1));
  assign cid_idx   = IW'(in_chan.cancel_id);
  assign scan_idx  = scan_r[IW-1:0];
  assign new_cnt   = pcnt_r - CountW'(1);

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_sts_r;
  assign out_chan.slot_id     = out_id_r;
  assign out_chan.fired       = out_fired_r;
  assign out_chan.count_left  = out_left_r;
  assign out_chan.next_expiry = out_next_r;
  assign out_chan.queue_empty = out_empty_r;
  assign out_chan.last        = out_last_r;

  always_comb begin
    state_nxt = state_r;
    scan_nxt = scan_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    valid_nxt = valid_r;
    due_nxt = due_r;
    now_nxt = now_r;
    req_nxt = req_r;
    delay_nxt = delay_r;
    count_nxt = count_r;
    hdr_sts_nxt = hdr_sts_r;
    hdr_id_nxt = hdr_id_r;
    nf_nxt = nf_r;
    oi_nxt = oi_r;
    found_nxt = 1'b0;
    pick_nxt = pick_r;
    best_nxt = best_r;
    pcnt_nxt = pcnt_r;
    pdly_nxt = pdly_r;
    any_nxt = 1'b0;
    min_nxt = min_r;
    out_valid_nxt = out_valid_r;
    out_sts_nxt = out_sts_r;
    out_id_nxt = out_id_r;
    out_fired_nxt = out_fired_r;
    out_left_nxt = out_left_r;
    out_next_nxt = out_next_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt = out_last_r;
    mem_we = 1'b0;
    mem_wa = pick_r;
    mem_wd = '{expiry: now_r + TimeW'(pdly_r), delay: pdly_r, count: new_cnt};
    rb_we = 1'b0;
    rb_wa = nf_r[IW-1:0];
    rb_wd = '{id: pick_r, left: new_cnt};

    // issue one slot read per cycle during the memory scans
    if ((state_r == S_DUE || state_r == S_PICK || state_r == S_MIN) && scan_r < SW'(N)) begin
      rd_vld_nxt = 1'b1;
      rd_idx_nxt = scan_idx;
      scan_nxt = scan_r + SW'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          req_nxt = in_chan.req_type;
          delay_nxt = in_chan.delay_ticks;
          count_nxt = in_chan.fire_count;
          hdr_sts_nxt = STS_OK;
          hdr_id_nxt = '0;
          nf_nxt = '0;
          oi_nxt = '0;
          scan_nxt = '0;
          state_nxt = S_MIN;
          if (in_chan.req_type == REQ_ADD) begin
            state_nxt = S_FREE;
          end else if (in_chan.req_type == REQ_CANCEL) begin
            if (32'(in_chan.cancel_id) < N && valid_r[cid_idx]) begin
              valid_nxt[cid_idx] = 1'b0;
            end else begin
              hdr_sts_nxt = STS_UNKNOWN;
            end
          end else if (in_chan.req_type == REQ_TICK) begin
            now_nxt = now_r + TimeW'(1);
            due_nxt = '0;
            state_nxt = S_DUE;
          end
        end
      end
      S_FREE: begin
        if (scan_r == SW'(N)) begin
          hdr_sts_nxt = STS_FULL;
          scan_nxt = '0;
          state_nxt = S_MIN;
        end else if (!valid_r[scan_idx]) begin
          mem_we = 1'b1;
          mem_wa = scan_idx;
          mem_wd = '{expiry: now_r + TimeW'(delay_r), delay: delay_r, count: count_r};
          valid_nxt[scan_idx] = 1'b1;
          hdr_id_nxt = 4'(scan_idx);
          scan_nxt = '0;
          state_nxt = S_MIN;
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end
      S_DUE: begin
        if (rd_vld_r) begin
          due_nxt[rd_idx_r] = valid_r[rd_idx_r] && (mem_q.expiry < now_r);
        end
        if (scan_done) begin
          scan_nxt = '0;
          rd_vld_nxt = 1'b0;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        found_nxt = found_r;
        // strict compare keeps the lower slot on ties
        if (rd_vld_r && due_r[rd_idx_r] && (!found_r || mem_q.expiry < best_r)) begin
          found_nxt = 1'b1;
          pick_nxt = rd_idx_r;
          best_nxt = mem_q.expiry;
          pcnt_nxt = mem_q.count;
          pdly_nxt = mem_q.delay;
        end
        if (scan_done) begin
          scan_nxt = '0;
          rd_vld_nxt = 1'b0;
          state_nxt = found_nxt ? S_PROC : S_MIN;
        end
      end
      S_PROC: begin
        due_nxt[pick_r] = 1'b0;
        if (pcnt_r != '0) begin
          rb_we = 1'b1;
          nf_nxt = nf_r + SW'(1);
          if (new_cnt != '0) begin
            mem_we = 1'b1;
          end else begin
            valid_nxt[pick_r] = 1'b0;
          end
        end else begin
          valid_nxt[pick_r] = 1'b0;
        end
        state_nxt = S_PICK;
      end
      S_MIN: begin
        any_nxt = any_r;
        if (rd_vld_r && valid_r[rd_idx_r] && (!any_r || mem_q.expiry < min_r)) begin
          any_nxt = 1'b1;
          min_nxt = mem_q.expiry;
        end
        if (scan_done) begin
          scan_nxt = '0;
          rd_vld_nxt = 1'b0;
          any_nxt = 1'b0;
          out_empty_nxt = !(any_r || (valid_r[rd_idx_r]));
          out_next_nxt = (rd_vld_r && valid_r[rd_idx_r] && (!any_r || mem_q.expiry < min_r))
                         ? mem_q.expiry : (any_r ? min_r : '0);
          state_nxt = S_LD_RD;
        end
      end
      S_LD_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        out_valid_nxt = 1'b1;
        if (oi_r < nf_r) begin
          out_sts_nxt = STS_OK;
          out_id_nxt = 4'(rbuf_q.id);
          out_fired_nxt = 1'b1;
          out_left_nxt = rbuf_q.left;
          out_last_nxt = 1'b0;
        end else begin
          out_sts_nxt = hdr_sts_r;
          out_id_nxt = hdr_id_r;
          out_fired_nxt = 1'b0;
          out_left_nxt = '0;
          out_last_nxt = 1'b1;
        end
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            oi_nxt = oi_r + SW'(1);
            state_nxt = S_LD_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      scan_r <= '0;
      rd_vld_r <= 1'b0;
      valid_r <= '0;
      due_r <= '0;
      now_r <= '0;
      nf_r <= '0;
      oi_r <= '0;
      found_r <= 1'b0;
      any_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      scan_r <= scan_nxt;
      rd_vld_r <= rd_vld_nxt;
      valid_r <= valid_nxt;
      due_r <= due_nxt;
      now_r <= now_nxt;
      nf_r <= nf_nxt;
      oi_r <= oi_nxt;
      found_r <= found_nxt;
      any_r <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    req_r <= req_nxt;
    delay_r <= delay_nxt;
    count_r <= count_nxt;
    hdr_sts_r <= hdr_sts_nxt;
    hdr_id_r <= hdr_id_nxt;
    pick_r <= pick_nxt;
    best_r <= best_nxt;
    pcnt_r <= pcnt_nxt;
    pdly_r <= pdly_nxt;
    min_r <= min_nxt;
    out_sts_r <= out_sts_nxt;
    out_id_r <= out_id_nxt;
    out_fired_r <= out_fired_nxt;
    out_left_r <= out_left_nxt;
    out_next_r <= out_next_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef ASSERT_OFF
  a_no_request_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !out_valid_r) else $error("request taken while a result is pending");

  a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nf_r <= SW'(N)) else $error("more firings buffered than slots");

  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !rd_vld_r) else $error("slot read in flight while idle");

  a_add_only_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FREE) |-> (req_r == REQ_ADD)) else $error("free slot search on non-add");
`endif

endmodule
